// ===== hdl/scs1_pkg.sv =====
// Package with the types, constants and key table of the set 1 scan code translator.
`timescale 1ns / 1ps
package scs1_pkg;

  localparam logic CmdScan     = 1'b0;
  localparam logic CmdLedWrite = 1'b1;

  localparam logic [7:0] ReleaseBit = 8'h80;
  localparam logic [7:0] CodeMask   = 8'h7F;

  localparam logic [7:0] KeyTab    = 8'd15;
  localparam logic [7:0] KeyLCtrl  = 8'd29;
  localparam logic [7:0] KeyLShift = 8'd42;
  localparam logic [7:0] KeyZ      = 8'd44;
  localparam logic [7:0] KeyX      = 8'd45;
  localparam logic [7:0] KeyC      = 8'd46;
  localparam logic [7:0] KeyV      = 8'd47;
  localparam logic [7:0] KeyRShift = 8'd54;
  localparam logic [7:0] KeyLAlt   = 8'd56;
  localparam logic [7:0] KeyCaps   = 8'd58;
  localparam logic [7:0] KeyF4     = 8'd62;
  localparam logic [7:0] KeyNum    = 8'd69;
  localparam logic [7:0] KeyScroll = 8'd70;
  localparam logic [7:0] KeyRCtrl  = 8'd97;
  localparam logic [7:0] KeyRAlt   = 8'd100;
  localparam logic [7:0] KeyDelete = 8'd111;

  localparam logic [2:0] LockCaps   = 3'b001;
  localparam logic [2:0] LockNum    = 3'b010;
  localparam logic [2:0] LockScroll = 3'b100;

  localparam logic [2:0] ComboNone      = 3'd0;
  localparam logic [2:0] ComboCtrlC     = 3'd1;
  localparam logic [2:0] ComboCtrlZ     = 3'd2;
  localparam logic [2:0] ComboCtrlV     = 3'd3;
  localparam logic [2:0] ComboCtrlX     = 3'd4;
  localparam logic [2:0] ComboAltTab    = 3'd5;
  localparam logic [2:0] ComboAltF4     = 3'd6;
  localparam logic [2:0] ComboCtrlAltDel = 3'd7;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [7:0] KEY_TABLE [128] = '{
    8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,
    8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,
    8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,
    8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd31,
    8'd32,  8'd33,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,  8'd39,
    8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
    8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,
    8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,
    8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,
    8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
    8'd80,  8'd81,  8'd82,  8'd83,  8'd0,   8'd0,   8'd86,  8'd87,
    8'd88,  8'd0,   8'd0,   8'd125, 8'd126, 8'd127, 8'd116, 8'd142,
    8'd0,   8'd0,   8'd0,   8'd143, 8'd0,   8'd217, 8'd156, 8'd103,
    8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111,
    8'd0,   8'd113, 8'd114, 8'd115, 8'd164, 8'd166, 8'd165, 8'd163,
    8'd172, 8'd155, 8'd140, 8'd157, 8'd96,  8'd97,  8'd100, 8'd102
  };

  typedef struct packed {
    logic       lock_wr;
    logic       unmapped;
    logic       rel;
    logic [7:0] key;
    logic       is_shift;
    logic       is_ctrl;
    logic       is_alt;
    logic [2:0] lock_tgl;
    logic [2:0] ctrl_combo;
    logic [2:0] alt_combo;
    logic       is_delete;
    logic [2:0] wmask;
    logic [2:0] wval;
  } dec_t;

endpackage

// ===== hdl/scs1_if.sv =====
// Handshake interfaces for the input and result words of the translator.
`timescale 1ns / 1ps
interface scs1_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] scan_code;
  logic [2:0] led_write_mask;
  logic [2:0] led_value;

  modport source (output valid, command, scan_code, led_write_mask, led_value,
                  input ready);
  modport sink (input valid, command, scan_code, led_write_mask, led_value,
                output ready);
endinterface

interface scs1_out_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic [7:0]  key_code;
  logic        key_pressed;
  logic        unmapped;
  logic [2:0]  combo_id;
  logic        shift_held;
  logic        ctrl_held;
  logic        alt_held;
  logic [2:0]  lock_leds;
  logic [31:0] press_total;
  logic [31:0] release_total;
  logic [31:0] unknown_total;

  modport source (output valid, event_valid, key_code, key_pressed, unmapped, combo_id,
                  shift_held, ctrl_held, alt_held, lock_leds, press_total,
                  release_total, unknown_total, input ready);
  modport sink (input valid, event_valid, key_code, key_pressed, unmapped, combo_id,
                shift_held, ctrl_held, alt_held, lock_leds, press_total,
                release_total, unknown_total, output ready);
endinterface

// ===== hdl/scs1_front.sv =====
// Front stage: accepts input words, looks up the key table and classifies each word.
`timescale 1ns / 1ps
module scs1_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  scs1_in_if.sink             in_i,
  output logic                dec_valid_o,
  output scs1_pkg::dec_t      dec_o,
  input  logic                dec_ready_i
);
  import scs1_pkg::*;

  logic       fv_q;
  dec_t       dec_q;
  dec_t       dec_d;
  logic [6:0] idx;
  logic [7:0] key;

  assign in_i.ready = !fv_q || dec_ready_i;

  always_comb begin
    idx = 7'(in_i.scan_code & CodeMask);
    key = KEY_TABLE[idx];
    dec_d.lock_wr    = (in_i.command == CmdLedWrite);
    dec_d.unmapped   = (in_i.command == CmdScan) && (key == 8'd0);
    dec_d.rel        = |(in_i.scan_code & ReleaseBit);
    dec_d.key        = key;
    dec_d.is_shift   = (key == KeyLShift) || (key == KeyRShift);
    dec_d.is_ctrl    = (key == KeyLCtrl) || (key == KeyRCtrl);
    dec_d.is_alt     = (key == KeyLAlt) || (key == KeyRAlt);
    dec_d.lock_tgl   = ((key == KeyCaps) ? LockCaps : 3'b000)
                     | ((key == KeyNum) ? LockNum : 3'b000)
                     | ((key == KeyScroll) ? LockScroll : 3'b000);
    dec_d.ctrl_combo = ComboNone;
    dec_d.alt_combo  = ComboNone;
    case (key)
      KeyC:    dec_d.ctrl_combo = ComboCtrlC;
      KeyZ:    dec_d.ctrl_combo = ComboCtrlZ;
      KeyV:    dec_d.ctrl_combo = ComboCtrlV;
      KeyX:    dec_d.ctrl_combo = ComboCtrlX;
      KeyTab:  dec_d.alt_combo  = ComboAltTab;
      KeyF4:   dec_d.alt_combo  = ComboAltF4;
      default: dec_d.ctrl_combo = ComboNone;
    endcase
    dec_d.is_delete  = (key == KeyDelete);
    dec_d.wmask      = in_i.led_write_mask;
    dec_d.wval       = in_i.led_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (in_i.ready) begin
      fv_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      dec_q <= dec_d;
    end
  end

  assign dec_valid_o = fv_q;
  assign dec_o       = dec_q;

endmodule

// ===== hdl/scs1_queue.sv =====
// Short queue of classified words between the front and back stages.
`timescale 1ns / 1ps
module scs1_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  scs1_pkg::dec_t      push_data_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output scs1_pkg::dec_t      pop_data_o,
  input  logic                pop_ready_i
);
  import scs1_pkg::*;

  dec_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= QPtrW'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= QPtrW'(rd_ptr_q + 1'b1);
      end
      cnt_q <= QCntW'(cnt_q + QCntW'(push) - QCntW'(pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/scs1_back.sv =====
// Back stage: applies each classified word to the flags and counters and registers the result.
`timescale 1ns / 1ps
module scs1_back #(
  parameter int unsigned CountWidth = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                dec_valid_i,
  input  scs1_pkg::dec_t      dec_i,
  output logic                dec_ready_o,
  scs1_out_if.source          out_o
);
  import scs1_pkg::*;

  logic                  ov_q;
  logic                  shift_q, shift_d;
  logic                  ctrl_q, ctrl_d;
  logic                  alt_q, alt_d;
  logic [2:0]            lock_q, lock_d;
  logic [CountWidth-1:0] press_q, press_d;
  logic [CountWidth-1:0] rel_q, rel_d;
  logic [CountWidth-1:0] unk_q, unk_d;
  logic                  ev_d, ev_q;
  logic [7:0]            key_d, key_q;
  logic                  pr_d, pr_q;
  logic                  unm_q;
  logic [2:0]            combo_d, combo_q;
  logic [63:0]           press_ext, rel_ext, unk_ext;
  logic                  pop;

  assign dec_ready_o = !ov_q || out_o.ready;
  assign pop         = dec_valid_i && dec_ready_o;

  always_comb begin
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    alt_d   = alt_q;
    lock_d  = lock_q;
    press_d = press_q;
    rel_d   = rel_q;
    unk_d   = unk_q;
    ev_d    = 1'b0;
    key_d   = 8'd0;
    pr_d    = 1'b0;
    combo_d = ComboNone;
    if (dec_i.lock_wr) begin
      lock_d = (lock_q & ~dec_i.wmask) | (dec_i.wval & dec_i.wmask);
    end else if (dec_i.unmapped) begin
      unk_d = unk_q + CountWidth'(1);
    end else begin
      if (dec_i.is_shift) begin
        shift_d = !dec_i.rel;
      end
      if (dec_i.is_ctrl) begin
        ctrl_d = !dec_i.rel;
      end
      if (dec_i.is_alt) begin
        alt_d = !dec_i.rel;
      end
      if (!dec_i.rel) begin
        lock_d  = lock_q ^ dec_i.lock_tgl;
        press_d = press_q + CountWidth'(1);
        combo_d = (ctrl_d ? dec_i.ctrl_combo : ComboNone)
                | (alt_d ? dec_i.alt_combo : ComboNone)
                | ((ctrl_d && alt_d && dec_i.is_delete) ? ComboCtrlAltDel : ComboNone);
      end else begin
        rel_d = rel_q + CountWidth'(1);
      end
      ev_d  = 1'b1;
      key_d = dec_i.key;
      pr_d  = !dec_i.rel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      shift_q <= 1'b0;
      ctrl_q  <= 1'b0;
      alt_q   <= 1'b0;
      lock_q  <= 3'b000;
      press_q <= '0;
      rel_q   <= '0;
      unk_q   <= '0;
    end else begin
      if (dec_ready_o) begin
        ov_q <= dec_valid_i;
      end
      if (pop) begin
        shift_q <= shift_d;
        ctrl_q  <= ctrl_d;
        alt_q   <= alt_d;
        lock_q  <= lock_d;
        press_q <= press_d;
        rel_q   <= rel_d;
        unk_q   <= unk_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ev_q    <= ev_d;
      key_q   <= key_d;
      pr_q    <= pr_d;
      unm_q   <= dec_i.unmapped;
      combo_q <= combo_d;
    end
  end

  assign press_ext = 64'(press_q);
  assign rel_ext   = 64'(rel_q);
  assign unk_ext   = 64'(unk_q);

  assign out_o.valid         = ov_q;
  assign out_o.event_valid   = ev_q;
  assign out_o.key_code      = key_q;
  assign out_o.key_pressed   = pr_q;
  assign out_o.unmapped      = unm_q;
  assign out_o.combo_id      = combo_q;
  assign out_o.shift_held    = shift_q;
  assign out_o.ctrl_held     = ctrl_q;
  assign out_o.alt_held      = alt_q;
  assign out_o.lock_leds     = lock_q;
  assign out_o.press_total   = press_ext[31:0];
  assign out_o.release_total = rel_ext[31:0];
  assign out_o.unknown_total = unk_ext[31:0];

  // A mapped press taken from the queue advances the press count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !dec_i.lock_wr && !dec_i.unmapped && !dec_i.rel
    |=> press_q == $past(press_q) + CountWidth'(1))
    else $error("press count did not advance on a mapped press");

  // An unmapped code never reports an event or a combination.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && unm_q |-> !ev_q && combo_q == ComboNone)
    else $error("unmapped word carries an event");

  // Combinations are only reported on a key press.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && combo_q != ComboNone |-> ev_q && pr_q)
    else $error("combination reported without a press");

endmodule

// ===== hdl/scan_code_set1_key_translator_top.sv =====
// Top level of the set 1 scan code to key code translator.
`timescale 1ns / 1ps
// Takes one word per clock cycle on in_i while out_o is ready, either a set 1 scan code byte
// or a direct write of the caps, num and scroll lock flags, and delivers exactly one result
// word per input word on out_o, in order. A word passes a classifying front register, a
// two-entry queue and the result register of the back stage. The back stage updates the held
// modifier flags, lock flags and the press, release and unmapped counters once per word, and
// sustains one word per cycle while out_o is ready. Counters are CountWidth bits wide and wrap;
// the totals show their low 32 bits.
module scan_code_set1_key_translator_top #(
  parameter int unsigned CountWidth = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scs1_in_if.sink     in_i,
  scs1_out_if.source  out_o
);
  import scs1_pkg::*;

  logic fq_valid;
  logic fq_ready;
  dec_t fq_data;
  logic qb_valid;
  logic qb_ready;
  dec_t qb_data;

  scs1_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .dec_valid_o (fq_valid),
    .dec_o       (fq_data),
    .dec_ready_i (fq_ready)
  );

  scs1_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_data_i  (fq_data),
    .push_ready_o (fq_ready),
    .pop_valid_o  (qb_valid),
    .pop_data_o   (qb_data),
    .pop_ready_i  (qb_ready)
  );

  scs1_back #(
    .CountWidth (CountWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_valid_i (qb_valid),
    .dec_i       (qb_data),
    .dec_ready_o (qb_ready),
    .out_o       (out_o)
  );

endmodule
